// ===== src/swld_pkg.sv =====
// ----------------------------------------------------------------------------
// swld_pkg
// Types and constants shared by the sync word, length prefixed deframer.
// ----------------------------------------------------------------------------
package swld_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PLEN_W   = 13;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned SYNC_W   = 32;
  localparam int unsigned RAWLEN_W = 16;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [SYNC_W-1:0] SYNC_RESET = 32'h1d03_6be5;

  localparam logic [0:0] REG_SYNC_PATTERN = 1'b0;

  localparam logic [1:0] SYNC_LAST = 2'd3;

  localparam logic [1:0] HDR_TYPE   = 2'd0;
  localparam logic [1:0] HDR_LEN_LO = 2'd1;
  localparam logic [1:0] HDR_LEN_HI = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_CONTENT = 3'b100
  } phase_t;

endpackage

// ===== src/swld_ifs.sv =====
// ----------------------------------------------------------------------------
// Deframer channels
// Valid/ready channels for received bytes and for framed results.
// ----------------------------------------------------------------------------
interface swld_in_if import swld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface swld_out_if import swld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  packet_type;
  logic [PLEN_W-1:0]  packet_length;
  logic [BYTE_W-1:0]  data_byte;
  logic [INDEX_W-1:0] byte_index;
  logic               has_data;
  logic               last_of_packet;

  modport source (output valid, output packet_type, output packet_length,
                  output data_byte, output byte_index, output has_data,
                  output last_of_packet, input ready);
  modport sink (input valid, input packet_type, input packet_length,
                input data_byte, input byte_index, input has_data,
                input last_of_packet, output ready);
endinterface

// ===== src/sync_word_length_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_word_length_deframer
// Hunts for a four-byte sync word, reads a type byte and a little-endian
// length, and hands out each content byte with its packet information.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                  Handshake
// in_chan   in   in_byte                                  valid/ready
// out_chan  out  type, length, data, index, flags         valid/ready
// apb       in   sync_pattern at byte address 0           psel/penable
//
// Each request is handled in the cycle it is accepted and its result, if
// any, sits in the result register on the next cycle: one byte per cycle.
// A new byte is taken whenever the result register is empty or is being
// drained in the same cycle.
// Reset is synchronous and returns the parser to sync hunting with the
// default sync word.
// ----------------------------------------------------------------------------
module sync_word_length_deframer
  import swld_pkg::*;
#(
  parameter int unsigned MAX_CONTENT_LEN = 4096
) (
  input  logic              clk,
  input  logic              rst,
  swld_in_if.sink           in_chan,
  swld_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned LEN_W = $clog2(MAX_CONTENT_LEN + 1);
  localparam logic [RAWLEN_W:0] MAX_LEN_EXT = (RAWLEN_W + 1)'(MAX_CONTENT_LEN);

  logic [SYNC_W-1:0]  sync_pattern;
  phase_t             phase;
  phase_t             phase_next;
  logic [1:0]         sync_matched;
  logic [1:0]         sync_matched_next;
  logic [1:0]         header_count;
  logic [1:0]         header_count_next;
  logic [BYTE_W-1:0]  type_hold;
  logic [BYTE_W-1:0]  type_hold_next;
  logic [BYTE_W-1:0]  length_low_hold;
  logic [BYTE_W-1:0]  length_low_hold_next;
  logic [LEN_W-1:0]   content_length;
  logic [LEN_W-1:0]   content_length_next;
  logic [LEN_W-1:0]   content_count;
  logic [LEN_W-1:0]   content_count_next;

  logic               out_valid;
  logic [BYTE_W-1:0]  out_type;
  logic [PLEN_W-1:0]  out_length;
  logic [BYTE_W-1:0]  out_data;
  logic [INDEX_W-1:0] out_index;
  logic               out_has_data;
  logic               out_last;

  logic               emit;
  logic [BYTE_W-1:0]  emit_type;
  logic [LEN_W-1:0]   emit_length;
  logic [BYTE_W-1:0]  emit_data;
  logic [LEN_W-1:0]   emit_index;
  logic               emit_has_data;
  logic               emit_last;

  logic [LEN_W+PLEN_W-1:0]  length_ext;
  logic [LEN_W+INDEX_W-1:0] index_ext;
  logic [RAWLEN_W-1:0]      raw_length;
  logic [LEN_W-1:0]         clamped_length;
  logic [LEN_W:0]           count_plus;
  logic [BYTE_W-1:0]        expect_byte;
  logic [BYTE_W-1:0]        b;
  logic                     accept;
  logic                     cfg_write;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !out_valid || out_chan.ready;
  assign b             = in_chan.in_byte;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SYNC_PATTERN);
  assign prdata    = (paddr[2] == REG_SYNC_PATTERN) ? sync_pattern : '0;

  assign raw_length     = {b, length_low_hold};
  assign clamped_length = ({1'b0, raw_length} > MAX_LEN_EXT) ?
                          LEN_W'(MAX_CONTENT_LEN) : LEN_W'(raw_length);
  assign count_plus     = {1'b0, content_count} + 1'b1;
  assign expect_byte    = sync_pattern[sync_matched*BYTE_W +: BYTE_W];

  always_comb begin
    phase_next           = phase;
    sync_matched_next    = sync_matched;
    header_count_next    = header_count;
    type_hold_next       = type_hold;
    length_low_hold_next = length_low_hold;
    content_length_next  = content_length;
    content_count_next   = content_count;
    emit                 = 1'b0;
    emit_type            = type_hold;
    emit_length          = content_length;
    emit_data            = '0;
    emit_index           = '0;
    emit_has_data        = 1'b0;
    emit_last            = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (header_count == HDR_TYPE) begin
          type_hold_next    = b;
          header_count_next = HDR_LEN_LO;
        end else if (header_count == HDR_LEN_LO) begin
          length_low_hold_next = b;
          header_count_next    = HDR_LEN_HI;
        end else begin
          content_length_next = clamped_length;
          content_count_next  = '0;
          header_count_next   = HDR_TYPE;
          if (clamped_length == '0) begin
            phase_next  = PH_HUNT;
            emit        = 1'b1;
            emit_length = '0;
            emit_last   = 1'b1;
          end else begin
            phase_next = PH_CONTENT;
          end
        end
      end
      PH_CONTENT: begin
        emit          = 1'b1;
        emit_data     = b;
        emit_index    = content_count;
        emit_has_data = 1'b1;
        emit_last     = (count_plus >= {1'b0, content_length});
        if (emit_last) begin
          phase_next         = PH_HUNT;
          content_count_next = '0;
        end else begin
          content_count_next = count_plus[LEN_W-1:0];
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if (b == expect_byte) begin
          if (sync_matched == SYNC_LAST) begin
            sync_matched_next = '0;
            header_count_next = HDR_TYPE;
            phase_next        = PH_HEADER;
          end else begin
            sync_matched_next = sync_matched + 2'd1;
          end
        end else begin
          sync_matched_next = '0;
        end
      end
    endcase
  end

  assign length_ext = {{PLEN_W{1'b0}}, emit_length};
  assign index_ext  = {{INDEX_W{1'b0}}, emit_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern  <= SYNC_RESET;
      phase         <= PH_HUNT;
      sync_matched  <= '0;
      header_count  <= HDR_TYPE;
      content_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        sync_pattern <= pwdata;
      end
      if (accept) begin
        phase         <= phase_next;
        sync_matched  <= sync_matched_next;
        header_count  <= header_count_next;
        content_count <= content_count_next;
        out_valid     <= emit;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      type_hold       <= type_hold_next;
      length_low_hold <= length_low_hold_next;
      content_length  <= content_length_next;
    end
    if (accept && emit) begin
      out_type     <= emit_type;
      out_length   <= length_ext[PLEN_W-1:0];
      out_data     <= emit_data;
      out_index    <= index_ext[INDEX_W-1:0];
      out_has_data <= emit_has_data;
      out_last     <= emit_last;
    end
  end

  assign out_chan.valid          = out_valid;
  assign out_chan.packet_type    = out_type;
  assign out_chan.packet_length  = out_length;
  assign out_chan.data_byte      = out_data;
  assign out_chan.byte_index     = out_index;
  assign out_chan.has_data       = out_has_data;
  assign out_chan.last_of_packet = out_last;

`ifndef ASSERT_OFF
  a_empty_notice_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_has_data |-> out_last && out_data == '0 && out_index == '0)
    else $error("empty packet notice is malformed");

  a_content_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_CONTENT |=> out_valid && out_has_data)
    else $error("content byte produced no result");

  a_hunt_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_HUNT |=> !out_valid)
    else $error("sync byte produced a result");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CONTENT |-> content_count < content_length)
    else $error("content count beyond packet length");

  a_last_leaves_content: assert property (@(posedge clk) disable iff (rst)
    accept && emit && emit_last |=> phase == PH_HUNT)
    else $error("parser did not return to hunting after packet end");
`endif

endmodule
